>>> rtl/pmjsot_pkg.sv
// ----------------------------------------------------------------------------
// pmjsot_pkg
// Shared types and constants of the pmj02 strata occupancy tracker: command
// and response words, opcodes and occupancy memory geometry.
// ----------------------------------------------------------------------------
package pmjsot_pkg;

  // Sizing
  localparam int MAX_LOG_SAMPLES = 10;
  localparam int COORD_FRAC_BITS = 16;
  localparam int LEVEL_W         = 4;
  localparam int CELL_W          = MAX_LOG_SAMPLES;
  localparam int WIDE_W          = COORD_FRAC_BITS + MAX_LOG_SAMPLES;

  // Occupancy memory: one row of 32-bit words per stratum level
  localparam int WORD_W          = 32;
  localparam int BIT_W           = 5;
  localparam int WSEL_W          = CELL_W - BIT_W;
  localparam int WORDS_PER_LEVEL = (1 << CELL_W) / WORD_W;
  localparam int MEM_WORDS       = (MAX_LOG_SAMPLES + 1) * WORDS_PER_LEVEL;
  localparam int MEM_AW          = LEVEL_W + WSEL_W;

  // Tree walk: depth up to MAX_LOG_SAMPLES/2, leaf index up to 2^depth
  localparam int DEP_W           = 3;
  localparam int LEAF_W          = 6;

  // Opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic [LEVEL_W-1:0]         level;
    logic [COORD_FRAC_BITS-1:0] point_x;
    logic [COORD_FRAC_BITS-1:0] point_y;
    logic [CELL_W-1:0]          cell_x;
    logic [CELL_W-1:0]          cell_y;
  } cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0] offset;
    logic              offset_is_y;
    logic              found;
    logic              last;
  } rsp_t;

endpackage

>>> rtl/pmj_strata_occupancy_tracker_core.sv
// ----------------------------------------------------------------------------
// pmj_strata_occupancy_tracker_core
// Elementary-interval occupancy tracker for pmj02 sampling: clear, insert
// a point into every stratum level, and query free leaf offsets of a cell.
// ----------------------------------------------------------------------------
// Usage
//   cmd channel (cmd_valid / cmd_stall / cmd) takes one command word at a
//   time; rsp channel (rsp_valid / rsp_stall / rsp) returns result words,
//   the final one of each command marked by rsp.last.
//   Occupancy lives in a 352 x 32 bit memory (11 levels x 1024 cells), one
//   read and one write port, registered read.
//   Clear: sweep over all 352 words of the memory, then one acknowledge word.
//   Insert: one read-modify-write per level, pipelined, then ack.
//   Query: depth-first walk of the x tree then the y tree, with a memory
//   read and then a decide step per visited node; at most 63 nodes per
//   tree. Free leaves stream out as they are found, one word held back
//   so that the final one can carry last; an empty query returns a
//   single word with found low.
//   Reset runs the same sweep over all 352 words; cmd_stall stays high meanwhile.
//   A stalled response holds the walk until the output register frees up;
//   one finished word can wait in that register while the walk goes on.
// ----------------------------------------------------------------------------
module pmj_strata_occupancy_tracker_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  pmjsot_pkg::cmd_t  cmd,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output pmjsot_pkg::rsp_t  rsp
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CLR    = 8'b0000_0010,
    S_INS    = 8'b0000_0100,
    S_INS_WB = 8'b0000_1000,
    S_QRD    = 8'b0001_0000,
    S_QEV    = 8'b0010_0000,
    S_QFIN   = 8'b0100_0000,
    S_ACK    = 8'b1000_0000
  } state_t;

  localparam int CW = pmjsot_pkg::CELL_W;
  localparam int LW = pmjsot_pkg::LEVEL_W;
  localparam int DW = pmjsot_pkg::DEP_W;
  localparam int JW = pmjsot_pkg::LEAF_W;
  localparam int AW = pmjsot_pkg::MEM_AW;
  localparam int FB = pmjsot_pkg::COORD_FRAC_BITS;
  localparam int XW = pmjsot_pkg::WIDE_W;
  localparam int BW = pmjsot_pkg::BIT_W;
  localparam int WW = pmjsot_pkg::WORD_W;

  // Position of the lowest set bit of a leaf index
  function automatic logic [DW-1:0] low_one(input logic [JW-1:0] v);
    logic [DW-1:0] pos;
    pos = '0;
    for (int i = JW - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = DW'(i);
      end
    end
    return pos;
  endfunction

  // Registers
  state_t                          state;
  logic [LW-1:0]                   level_count;
  logic [AW-1:0]                   clr_cnt;
  logic                            clr_ack;
  logic [LW-1:0]                   ins_lvl;
  logic [FB-1:0]                   px;
  logic [FB-1:0]                   py;
  logic                            wp_valid;
  logic [AW-1:0]                   wp_addr;
  logic [BW-1:0]                   wp_bit;
  logic [CW-1:0]                   qx;
  logic [CW-1:0]                   qy;
  logic                            walk_y;
  logic [DW-1:0]                   dep;
  logic [JW-1:0]                   leaf;
  logic [BW-1:0]                   rd_bit;
  logic                            pend_valid;
  logic [CW-1:0]                   pend_off;
  logic                            pend_is_y;

  // Occupancy memory
  logic [WW-1:0]                   occ_mem [pmjsot_pkg::MEM_WORDS];
  logic [WW-1:0]                   mem_rdata;
  logic                            mem_re;
  logic [AW-1:0]                   mem_raddr;
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [WW-1:0]                   mem_wdata;

  // Combinational
  logic                            can_load;
  logic                            rsp_load;
  logic [LW-1:0]                   lv_sat;
  logic [DW-1:0]                   walk_dep;
  logic [LW-1:0]                   half_hi;
  logic [CW-1:0]                   dim_mask;
  logic [CW-1:0]                   wx;
  logic [CW-1:0]                   wy;
  logic [LW-1:0]                   wstart;
  logic [DW-1:0]                   rem;
  logic [CW-1:0]                   pfx;
  logic [LW-1:0]                   node_lvl;
  logic [CW-1:0]                   node_x;
  logic [CW-1:0]                   node_y;
  logic [CW-1:0]                   node_idx;
  logic [LW-1:0]                   ins_col_sh;
  logic [XW-1:0]                   ins_xw;
  logic [XW-1:0]                   ins_yw;
  logic [CW-1:0]                   ins_idx;
  logic                            node_taken;
  logic                            at_leaf;
  logic [JW-1:0]                   leaf_sum;
  logic                            walk_done;
  logic [DW-1:0]                   next_dep;
  logic [CW-1:0]                   leaf_off;
  logic                            emit_leaf;

  assign cmd_stall = (state != S_IDLE);
  assign can_load  = !rsp_valid || !rsp_stall;

  assign lv_sat = (cmd.level > LW'(pmjsot_pkg::MAX_LOG_SAMPLES)) ?
                  LW'(pmjsot_pkg::MAX_LOG_SAMPLES) : cmd.level;

  // Walk geometry: both trees are floor(k/2) deep
  assign walk_dep = level_count[LW-1:1];
  assign half_hi  = level_count - LW'(walk_dep);
  assign dim_mask = (CW'(1) << half_hi) - CW'(1);

  assign wx     = (walk_y && level_count[0])  ? (qx >> 1) : qx;
  assign wy     = (!walk_y && level_count[0]) ? (qy >> 1) : qy;
  assign wstart = walk_y ? half_hi : LW'(walk_dep);

  // Node address for the current (leaf, depth) position
  always_comb begin
    rem      = walk_dep - dep;
    pfx      = CW'(leaf >> rem);
    node_lvl = walk_y ? (wstart + LW'(dep)) : (wstart - LW'(dep));
    node_x   = walk_y ? (wx >> dep) : ((wx << dep) + pfx);
    node_y   = walk_y ? ((wy << dep) + pfx) : (wy >> dep);
    node_idx = (node_y << (level_count - node_lvl)) + node_x;
  end

  // Insert cell on level ins_lvl
  always_comb begin
    ins_col_sh = level_count - ins_lvl;
    ins_xw     = XW'(px) << ins_col_sh;
    ins_yw     = XW'(py) << ins_lvl;
    ins_idx    = (ins_yw[XW-1:FB] << ins_col_sh) + ins_xw[XW-1:FB];
  end

  // Walk step decision
  always_comb begin
    node_taken = mem_rdata[rd_bit];
    at_leaf    = (dep == walk_dep);
    leaf_sum   = leaf + (JW'(1) << rem);
    walk_done  = (leaf_sum == (JW'(1) << walk_dep));
    next_dep   = walk_dep - low_one(leaf_sum);
    leaf_off   = (walk_y ? (wy << walk_dep) : (wx << walk_dep)) + CW'(leaf);
    emit_leaf  = !node_taken && at_leaf;
  end

  // Output register takes a new word this cycle
  always_comb begin
    unique case (state)
      S_QEV:   rsp_load = emit_leaf && pend_valid && can_load;
      S_QFIN:  rsp_load = can_load;
      S_ACK:   rsp_load = can_load;
      default: rsp_load = 1'b0;
    endcase
  end

  // Memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = {node_lvl, node_idx[CW-1:BW]};
    mem_we    = 1'b0;
    mem_waddr = wp_addr;
    mem_wdata = mem_rdata | (WW'(1) << wp_bit);
    unique case (state)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      S_INS: begin
        mem_re    = 1'b1;
        mem_raddr = {ins_lvl, ins_idx[CW-1:BW]};
        mem_we    = wp_valid;
      end
      S_INS_WB: begin
        mem_we    = wp_valid;
      end
      S_QRD: begin
        mem_re    = 1'b1;
      end
      default: begin
        mem_re    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= occ_mem[mem_raddr];
    end
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      level_count <= '0;
      clr_cnt     <= '0;
      clr_ack     <= 1'b0;
      wp_valid    <= 1'b0;
      pend_valid  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      // output register: load a new word or release the taken one
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.opcode)
              pmjsot_pkg::OP_CLEAR: begin
                level_count <= lv_sat;
                clr_cnt     <= '0;
                clr_ack     <= 1'b1;
                state       <= S_CLR;
              end
              pmjsot_pkg::OP_INSERT: begin
                px      <= cmd.point_x;
                py      <= cmd.point_y;
                ins_lvl <= '0;
                state   <= S_INS;
              end
              pmjsot_pkg::OP_QUERY: begin
                qx         <= cmd.cell_x & dim_mask;
                qy         <= cmd.cell_y & dim_mask;
                walk_y     <= 1'b0;
                dep        <= '0;
                leaf       <= '0;
                pend_valid <= 1'b0;
                state      <= S_QRD;
              end
              default: begin
                state <= S_ACK;
              end
            endcase
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(pmjsot_pkg::MEM_WORDS - 1)) begin
            state <= clr_ack ? S_ACK : S_IDLE;
          end
        end
        S_INS: begin
          // read level ins_lvl now, write it back next cycle
          wp_valid <= 1'b1;
          wp_addr  <= mem_raddr;
          wp_bit   <= ins_idx[BW-1:0];
          if (ins_lvl == level_count) begin
            state <= S_INS_WB;
          end else begin
            ins_lvl <= ins_lvl + LW'(1);
          end
        end
        S_INS_WB: begin
          wp_valid <= 1'b0;
          state    <= S_ACK;
        end
        S_QRD: begin
          rd_bit <= node_idx[BW-1:0];
          state  <= S_QEV;
        end
        S_QEV: begin
          if (emit_leaf && pend_valid && !can_load) begin
            state <= S_QEV;
          end else begin
            // hold back the newest free leaf, push out the one before it
            if (emit_leaf) begin
              if (pend_valid) begin
                rsp <= '{offset: pend_off, offset_is_y: pend_is_y,
                         found: 1'b1, last: 1'b0};
              end
              pend_valid <= 1'b1;
              pend_off   <= leaf_off;
              pend_is_y  <= walk_y;
            end
            if (!node_taken && !at_leaf) begin
              dep   <= dep + DW'(1);
              state <= S_QRD;
            end else if (!walk_done) begin
              leaf  <= leaf_sum;
              dep   <= next_dep;
              state <= S_QRD;
            end else if (!walk_y) begin
              walk_y <= 1'b1;
              leaf   <= '0;
              dep    <= '0;
              state  <= S_QRD;
            end else begin
              state <= S_QFIN;
            end
          end
        end
        S_QFIN: begin
          if (can_load) begin
            rsp        <= '{offset: pend_valid ? pend_off : '0,
                            offset_is_y: pend_valid && pend_is_y,
                            found: pend_valid, last: 1'b1};
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_ACK: begin
          if (can_load) begin
            rsp   <= '{offset: '0, offset_is_y: 1'b0, found: 1'b0, last: 1'b1};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
